// ===== sv/crcpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcpf_pkg
// Shared types, register map and CRC-16 byte update for the packet framer.
// ----------------------------------------------------------------------------
package crcpf_pkg;

  // crc-16 constants, msb first, no reflection, no final xor
  localparam logic [15:0] CRC_POLY     = 16'h8005;
  localparam logic [15:0] CRC_SEED     = 16'hFFFF;
  localparam logic [3:0]  MAX_PREAMBLE = 4'd8;

  // register map, word index on the configuration port
  localparam int unsigned AddrWidth = 4;
  localparam logic [1:0] REG_COMMAND  = 2'd0;
  localparam logic [1:0] REG_PRE_CNT  = 2'd1;
  localparam logic [1:0] REG_PRE_VAL  = 2'd2;
  localparam logic [1:0] REG_SYNC     = 2'd3;

  // register reset values
  localparam logic [7:0]  RST_COMMAND = 8'h66;
  localparam logic [3:0]  RST_PRE_CNT = 4'd8;
  localparam logic [7:0]  RST_PRE_VAL = 8'hAA;
  localparam logic [15:0] RST_SYNC    = 16'hD391;

  // framing configuration seen by the datapath
  typedef struct packed {
    logic [7:0]  command_byte;
    logic [3:0]  preamble_count;
    logic [7:0]  preamble_value;
    logic [15:0] sync_word;
  } cfg_t;

  // fold one byte into the crc, one bit per step
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data_in);
    logic [15:0] crc;
    logic [7:0]  data;
    logic        fb;
    crc  = crc_in;
    data = data_in;
    for (int b = 0; b < 8; b++) begin
      fb   = crc[15] ^ data[7];
      crc  = {crc[14:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
      data = {data[6:0], 1'b0};
    end
    return crc;
  endfunction

endpackage

// ===== sv/crcpf_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcpf_regs
// Configuration register file with a simple APB-style slave port.
// ----------------------------------------------------------------------------
module crcpf_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [crcpf_pkg::AddrWidth-1:0]    paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output crcpf_pkg::cfg_t                    cfg_o
);
  import crcpf_pkg::*;

  logic [7:0]  command_q;
  logic [3:0]  pre_cnt_q;
  logic [7:0]  pre_val_q;
  logic [15:0] sync_q;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      command_q <= RST_COMMAND;
      pre_cnt_q <= RST_PRE_CNT;
      pre_val_q <= RST_PRE_VAL;
      sync_q    <= RST_SYNC;
    end else if (wr_en) begin
      case (reg_idx)
        REG_COMMAND: command_q <= pwdata[7:0];
        REG_PRE_CNT: pre_cnt_q <= pwdata[3:0];
        REG_PRE_VAL: pre_val_q <= pwdata[7:0];
        REG_SYNC:    sync_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_COMMAND: prdata = {24'd0, command_q};
      REG_PRE_CNT: prdata = {28'd0, pre_cnt_q};
      REG_PRE_VAL: prdata = {24'd0, pre_val_q};
      REG_SYNC:    prdata = {16'd0, sync_q};
      default:     prdata = 32'd0;
    endcase
  end

  assign cfg_o = '{command_byte:   command_q,
                   preamble_count: pre_cnt_q,
                   preamble_value: pre_val_q,
                   sync_word:      sync_q};

endmodule

// ===== sv/crc16_packet_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_packet_framer
// Frames payload bytes with command, preamble and sync header plus CRC-16.
// ----------------------------------------------------------------------------
// An item is one payload byte (or an empty-frame marker). It enters an item
// register, where the CRC and frame state are already updated, and a small
// sequencer then sends its result bytes one per cycle, while the output is
// not stalled, through an output register. A mid-frame byte gives one result,
// so a frame body streams at one byte per cycle when not stalled. The first
// item of a frame adds 3 + min(preamble_count, 8) header bytes and the closing
// item adds the two CRC bytes, so such an item gives up to 14 result bytes;
// the next item is taken in the cycle its final result is loaded.
// ----------------------------------------------------------------------------
module crc16_packet_framer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [crcpf_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      payload_byte_i,
  input  logic                            last_byte_i,
  input  logic                            empty_frame_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      out_byte_o,
  output logic                            run_last_o,
  output logic                            frame_end_o
);
  import crcpf_pkg::*;

  typedef enum logic [2:0] {
    PH_CMD, PH_PRE, PH_SYNC_H, PH_SYNC_L, PH_DATA, PH_CRC_H, PH_CRC_L
  } phase_e;

  cfg_t cfg;

  // frame state
  logic [15:0] crc_q, crc_d;
  logic        in_frame_q, in_frame_d;

  // item register and sequencer
  logic        h_valid_q, h_valid_d;
  logic [7:0]  h_data_q, h_data_d;
  logic        h_empty_q, h_empty_d;
  logic        h_close_q, h_close_d;
  logic [15:0] h_crc_q, h_crc_d;
  phase_e      phase_q, phase_d;
  logic [2:0]  pcnt_q, pcnt_d;

  // output register
  logic        o_valid_q, o_valid_d;
  logic [7:0]  o_byte_q, o_byte_d;
  logic        o_run_last_q, o_run_last_d;
  logic        o_fend_q, o_fend_d;

  logic        emit, emit_final, item_free, in_acc;
  logic [3:0]  pre_n;
  logic [7:0]  emit_byte;
  logic [15:0] crc_upd, crc_out;
  logic        close_in;

  crcpf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // saturated preamble length
  assign pre_n = (cfg.preamble_count > MAX_PREAMBLE) ? MAX_PREAMBLE : cfg.preamble_count;

  // handshake
  assign emit       = h_valid_q & (~o_valid_q | ~out_stall_i);
  assign emit_final = (phase_q == PH_CRC_L) | ((phase_q == PH_DATA) & ~h_close_q);
  assign item_free  = ~h_valid_q | (emit & emit_final);
  assign in_stall_o = ~item_free;
  assign in_acc     = in_valid_i & item_free;

  // crc and frame state update at accept
  assign crc_upd  = crc16_byte(crc_q, payload_byte_i);
  assign crc_out  = empty_frame_i ? crc_q : crc_upd;
  assign close_in = empty_frame_i | last_byte_i;

  // byte of the current phase
  always_comb begin
    case (phase_q)
      PH_CMD:    emit_byte = cfg.command_byte;
      PH_PRE:    emit_byte = cfg.preamble_value;
      PH_SYNC_H: emit_byte = cfg.sync_word[15:8];
      PH_SYNC_L: emit_byte = cfg.sync_word[7:0];
      PH_DATA:   emit_byte = h_data_q;
      PH_CRC_H:  emit_byte = h_crc_q[15:8];
      PH_CRC_L:  emit_byte = h_crc_q[7:0];
      default:   emit_byte = 8'd0;
    endcase
  end

  // next-state logic
  always_comb begin
    crc_d        = crc_q;
    in_frame_d   = in_frame_q;
    h_valid_d    = h_valid_q;
    h_data_d     = h_data_q;
    h_empty_d    = h_empty_q;
    h_close_d    = h_close_q;
    h_crc_d      = h_crc_q;
    phase_d      = phase_q;
    pcnt_d       = pcnt_q;
    o_valid_d    = o_valid_q & out_stall_i;
    o_byte_d     = o_byte_q;
    o_run_last_d = o_run_last_q;
    o_fend_d     = o_fend_q;

    // sequencer step
    if (emit) begin
      o_valid_d    = 1'b1;
      o_byte_d     = emit_byte;
      o_run_last_d = emit_final;
      o_fend_d     = (phase_q == PH_CRC_L);
      case (phase_q)
        PH_CMD: begin
          pcnt_d  = 3'd0;
          phase_d = (pre_n != 4'd0) ? PH_PRE : PH_SYNC_H;
        end
        PH_PRE: begin
          pcnt_d  = pcnt_q + 3'd1;
          phase_d = (({1'b0, pcnt_q} + 4'd1) == pre_n) ? PH_SYNC_H : PH_PRE;
        end
        PH_SYNC_H: phase_d = PH_SYNC_L;
        PH_SYNC_L: phase_d = h_empty_q ? PH_CRC_H : PH_DATA;
        PH_DATA:   phase_d = PH_CRC_H;
        PH_CRC_H:  phase_d = PH_CRC_L;
        PH_CRC_L:  phase_d = PH_CRC_L;
        default:   phase_d = PH_CRC_L;
      endcase
      if (emit_final) begin
        h_valid_d = 1'b0;
      end
    end

    // accept a new item
    if (in_acc) begin
      h_valid_d = 1'b1;
      h_data_d  = payload_byte_i;
      h_empty_d = empty_frame_i;
      h_close_d = close_in;
      h_crc_d   = crc_out;
      pcnt_d    = 3'd0;
      if (!in_frame_q) begin
        phase_d = PH_CMD;
      end else if (!empty_frame_i) begin
        phase_d = PH_DATA;
      end else begin
        phase_d = PH_CRC_H;
      end
      if (close_in) begin
        crc_d      = CRC_SEED;
        in_frame_d = 1'b0;
      end else begin
        crc_d      = crc_out;
        in_frame_d = 1'b1;
      end
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q        <= CRC_SEED;
      in_frame_q   <= 1'b0;
      h_valid_q    <= 1'b0;
      h_data_q     <= 8'd0;
      h_empty_q    <= 1'b0;
      h_close_q    <= 1'b0;
      h_crc_q      <= CRC_SEED;
      phase_q      <= PH_CMD;
      pcnt_q       <= 3'd0;
      o_valid_q    <= 1'b0;
      o_byte_q     <= 8'd0;
      o_run_last_q <= 1'b0;
      o_fend_q     <= 1'b0;
    end else begin
      crc_q        <= crc_d;
      in_frame_q   <= in_frame_d;
      h_valid_q    <= h_valid_d;
      h_data_q     <= h_data_d;
      h_empty_q    <= h_empty_d;
      h_close_q    <= h_close_d;
      h_crc_q      <= h_crc_d;
      phase_q      <= phase_d;
      pcnt_q       <= pcnt_d;
      o_valid_q    <= o_valid_d;
      o_byte_q     <= o_byte_d;
      o_run_last_q <= o_run_last_d;
      o_fend_q     <= o_fend_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_byte_o  = o_byte_q;
  assign run_last_o  = o_run_last_q;
  assign frame_end_o = o_fend_q;

  // the closing crc byte is always the final result of its item
  a_fend_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> run_last_o)
    else $error("frame end without run last");

  // no frame open means the crc sits at its initial value
  a_crc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> crc_q == CRC_SEED)
    else $error("crc not reset while no frame open");

  // preamble counter stays below the saturated count
  a_pre_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_valid_q && phase_q == PH_PRE |-> {1'b0, pcnt_q} < pre_n)
    else $error("preamble counter overrun");

endmodule

// ===== tb/sv/tb_crc16_packet_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc16_packet_framer
// Self-checking bench for the packet framer. A behavioral framer tracks the
// open frame, the running CRC-16 and the register copy, and queues the bytes
// each accepted item must produce; a monitor pops them in order. A short
// table of hand-picked items runs first, then random frames under several
// register settings, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_crc16_packet_framer;
  import crcpf_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 380;
  localparam int unsigned PHASES       = 5;
  localparam int unsigned SETTLE       = 20;
  localparam int unsigned IDLE_PAD     = 4;
  localparam int unsigned CYCLE_LIMIT  = 800000;
  localparam int unsigned DIR_ROWS     = 19;

  // one framed output byte as the monitor sees it
  typedef struct {
    logic [7:0] data;
    logic       run_last;
    logic       frame_end;
  } framed_byte_t;

  // one row of the directed table; byte count and crc typed in by hand
  typedef struct packed {
    logic [7:0]  payload;
    logic        last;
    logic        empty;
    logic [4:0]  n_bytes;
    logic        crc_known;
    logic [15:0] crc;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [7:0]           payload_byte_i;
  logic                 last_byte_i;
  logic                 empty_frame_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [7:0]           out_byte_o;
  logic                 run_last_o;
  logic                 frame_end_o;

  // framer copy kept by the bench
  cfg_t         frame_cfg;
  logic [15:0]  crc_acc;
  logic         open_frame;
  framed_byte_t bytes_due[$];

  int unsigned  mismatch_cnt;
  int unsigned  cycle_cnt;
  int unsigned  stall_left;
  logic         stall_on;
  logic         tx_burst;
  framed_byte_t head;

  crc16_packet_framer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .payload_byte_i(payload_byte_i),
    .last_byte_i   (last_byte_i),
    .empty_frame_i (empty_frame_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .frame_end_o   (frame_end_o)
  );

  // 4 ns clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // crc-16, whole byte xored into the top, then eight shifts
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] r;
    r = crc ^ {d, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  // work out the bytes one item produces and queue them
  task automatic frame_and_crc(input logic [7:0] payload, input logic last,
                               input logic empty, output int unsigned n,
                               output logic [15:0] crc_out);
    logic [7:0]   bytes [16];
    logic [3:0]   pre;
    logic         closes;
    framed_byte_t fb;
    n       = 0;
    crc_out = 16'h0000;
    closes  = empty || last;
    if (!open_frame) begin
      bytes[n] = frame_cfg.command_byte;
      n++;
      pre = (frame_cfg.preamble_count > MAX_PREAMBLE) ? MAX_PREAMBLE
                                                       : frame_cfg.preamble_count;
      for (int i = 0; i < pre; i++) begin
        bytes[n] = frame_cfg.preamble_value;
        n++;
      end
      bytes[n]     = frame_cfg.sync_word[15:8];
      bytes[n + 1] = frame_cfg.sync_word[7:0];
      n += 2;
    end
    if (!empty) begin
      bytes[n] = payload;
      n++;
      crc_acc = crc_fold(crc_acc, payload);
    end
    if (closes) begin
      bytes[n]     = crc_acc[15:8];
      bytes[n + 1] = crc_acc[7:0];
      n += 2;
      crc_out    = crc_acc;
      crc_acc    = CRC_SEED;
      open_frame = 1'b0;
    end else begin
      open_frame = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      fb.data      = bytes[i];
      fb.run_last  = (i == n - 1);
      fb.frame_end = (i == n - 1) && closes;
      bytes_due.push_back(fb);
    end
  endtask

  // output stall, mostly short, now and then long
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_on && $urandom_range(0, 99) < 25) begin
      stall_left  <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                  : $urandom_range(8, 30);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // output monitor, compares against the oldest queued byte
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (bytes_due.size() == 0) begin
        $display("%0t: unexpected item: expected none, got byte %02h", $time, out_byte_o);
        mismatch_cnt++;
      end else begin
        head = bytes_due.pop_front();
        if (out_byte_o !== head.data) begin
          $display("%0t: out_byte expected %02h, got %02h", $time, head.data, out_byte_o);
          mismatch_cnt++;
        end
        if (run_last_o !== head.run_last) begin
          $display("%0t: run_last expected %0b, got %0b", $time, head.run_last, run_last_o);
          mismatch_cnt++;
        end
        if (frame_end_o !== head.frame_end) begin
          $display("%0t: frame_end expected %0b, got %0b", $time, head.frame_end,
                   frame_end_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // input gap before the next item
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tx_burst || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // present one item, wait for it to be taken, then predict it
  task automatic send_item(input logic [7:0] payload, input logic last,
                           input logic empty, output int unsigned n_res,
                           output logic [15:0] crc_out);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    payload_byte_i <= payload;
    last_byte_i    <= last;
    empty_frame_i  <= empty;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    frame_and_crc(payload, last, empty, n_res, crc_out);
    @(negedge clk_i);
  endtask

  // hold the input until every queued byte has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (bytes_due.size() != 0) @(negedge clk_i);
    repeat (IDLE_PAD) @(negedge clk_i);
  endtask

  // one apb transfer, setup then access
  task automatic apb_xfer(input logic [1:0] idx, input logic wr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] reg_mask(input logic [1:0] idx);
    case (idx)
      REG_COMMAND: return 32'h0000_00FF;
      REG_PRE_CNT: return 32'h0000_000F;
      REG_PRE_VAL: return 32'h0000_00FF;
      default:     return 32'h0000_FFFF;
    endcase
  endfunction

  // read a register and compare the bits it holds
  task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
    logic [31:0] got;
    logic [31:0] m;
    m = reg_mask(idx);
    apb_xfer(idx, 1'b0, $urandom(), got);
    if ((got & m) !== (want & m)) begin
      $display("%0t: register %0d expected %h, got %h", $time, idx, want & m, got & m);
      mismatch_cnt++;
    end
  endtask

  // write a register with junk above its width, update the copy, read back
  task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] m;
    logic [31:0] unused;
    m = reg_mask(idx);
    apb_xfer(idx, 1'b1, (value & m) | ($urandom() & ~m), unused);
    case (idx)
      REG_COMMAND: frame_cfg.command_byte   = value[7:0];
      REG_PRE_CNT: frame_cfg.preamble_count = value[3:0];
      REG_PRE_VAL: frame_cfg.preamble_value = value[7:0];
      default:     frame_cfg.sync_word      = value[15:0];
    endcase
    check_reg(idx, value);
  endtask

  task automatic set_all(input logic [7:0] cmd, input logic [3:0] cnt,
                         input logic [7:0] val, input logic [15:0] sync);
    set_reg(REG_COMMAND, {24'h0, cmd});
    set_reg(REG_PRE_CNT, {28'h0, cnt});
    set_reg(REG_PRE_VAL, {24'h0, val});
    set_reg(REG_SYNC,    {16'h0, sync});
  endtask

  function automatic stim_row_t row(input logic [7:0] payload, input logic last,
                                    input logic empty, input logic [4:0] n_bytes,
                                    input logic crc_known, input logic [15:0] crc);
    return {payload, last, empty, n_bytes, crc_known, crc};
  endfunction

  // stimulus
  initial begin
    stim_row_t   dir [DIR_ROWS];
    int unsigned n_res;
    logic [15:0] crc_out;
    int unsigned sent;
    int unsigned target;
    int unsigned r;
    int unsigned len;
    logic        by_empty;

    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    payload_byte_i = 8'h00;
    last_byte_i    = 1'b0;
    empty_frame_i  = 1'b0;
    out_stall_i    = 1'b0;
    stall_left     = 0;
    stall_on       = 1'b1;
    tx_burst       = 1'b0;
    mismatch_cnt   = 0;
    cycle_cnt      = 0;
    frame_cfg      = {RST_COMMAND, RST_PRE_CNT, RST_PRE_VAL, RST_SYNC};
    crc_acc        = CRC_SEED;
    open_frame     = 1'b0;
    sent           = 0;

    // reset defaults give an 11-byte header
    dir[0]  = row(8'h5A, 1'b1, 1'b1, 5'd13, 1'b1, 16'hFFFF); // empty, no frame open
    dir[1]  = row(8'h00, 1'b1, 1'b0, 5'd14, 1'b0, 16'h0000); // one-byte frame
    dir[2]  = row(8'hFF, 1'b0, 1'b0, 5'd12, 1'b0, 16'h0000);
    dir[3]  = row(8'h80, 1'b0, 1'b0, 5'd1,  1'b0, 16'h0000);
    dir[4]  = row(8'h01, 1'b1, 1'b0, 5'd3,  1'b0, 16'h0000);
    dir[5]  = row(8'h12, 1'b0, 1'b0, 5'd12, 1'b0, 16'h0000);
    dir[6]  = row(8'hA5, 1'b1, 1'b1, 5'd2,  1'b0, 16'h0000); // empty closes open frame
    dir[7]  = row(8'h3C, 1'b0, 1'b1, 5'd13, 1'b1, 16'hFFFF);
    dir[8]  = row(8'hFF, 1'b1, 1'b0, 5'd14, 1'b0, 16'h0000);
    dir[9]  = row(8'h00, 1'b0, 1'b0, 5'd12, 1'b0, 16'h0000);
    dir[10] = row(8'h00, 1'b0, 1'b0, 5'd1,  1'b0, 16'h0000);
    dir[11] = row(8'hFF, 1'b0, 1'b0, 5'd1,  1'b0, 16'h0000);
    dir[12] = row(8'h7F, 1'b0, 1'b0, 5'd1,  1'b0, 16'h0000);
    dir[13] = row(8'h55, 1'b0, 1'b0, 5'd1,  1'b0, 16'h0000);
    dir[14] = row(8'hAA, 1'b1, 1'b0, 5'd3,  1'b0, 16'h0000);
    dir[15] = row(8'h01, 1'b0, 1'b1, 5'd13, 1'b1, 16'hFFFF);
    dir[16] = row(8'hC3, 1'b0, 1'b0, 5'd12, 1'b0, 16'h0000);
    dir[17] = row(8'hFE, 1'b1, 1'b1, 5'd2,  1'b0, 16'h0000);
    dir[18] = row(8'h00, 1'b0, 1'b1, 5'd13, 1'b1, 16'hFFFF);

    // apply reset, then release it
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // register values after reset
    check_reg(REG_COMMAND, {24'h0, RST_COMMAND});
    check_reg(REG_PRE_CNT, {28'h0, RST_PRE_CNT});
    check_reg(REG_PRE_VAL, {24'h0, RST_PRE_VAL});
    check_reg(REG_SYNC,    {16'h0, RST_SYNC});

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(dir[i].payload, dir[i].last, dir[i].empty, n_res, crc_out);
      sent++;
      if (n_res != dir[i].n_bytes) begin
        $display("%0t: row %0d byte count expected %0d, got %0d", $time, i,
                 dir[i].n_bytes, n_res);
        mismatch_cnt++;
      end
      if (dir[i].crc_known && crc_out !== dir[i].crc) begin
        $display("%0t: row %0d crc expected %04h, got %04h", $time, i, dir[i].crc, crc_out);
        mismatch_cnt++;
      end
    end
    wait_drained();

    // random frames under several register settings
    for (int ph = 0; ph < PHASES; ph++) begin
      stall_on = (ph != 2);
      case (ph)
        0:       set_all(8'h00, 4'd0, 8'h00, 16'h0000);
        1:       set_all(8'hFF, 4'd15, 8'hFF, 16'hFFFF);
        2:       set_all(8'($urandom()), 4'd9, 8'($urandom()), 16'($urandom()));
        3:       set_all(8'($urandom()), 4'($urandom_range(0, 15)),
                         8'($urandom()), 16'($urandom()));
        default: set_all(8'($urandom()), 4'($urandom_range(1, 8)),
                         8'($urandom()), 16'($urandom()));
      endcase
      target = (ph + 1) * RANDOM_ITEMS / PHASES;
      while (sent < target) begin
        r        = $urandom_range(0, 99);
        tx_burst = ($urandom_range(0, 3) == 0);
        if (r < 8) begin
          // noise: any field combination
          send_item(8'($urandom()), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    n_res, crc_out);
          sent++;
        end else if (r < 14) begin
          send_item(8'($urandom()), 1'($urandom_range(0, 1)), 1'b1, n_res, crc_out);
          sent++;
        end else if (r < 17) begin
          wait_drained();
        end else begin
          // well-formed frame, mostly short, closed by last or by an empty item
          len      = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 6);
          by_empty = ($urandom_range(0, 9) == 0);
          for (int k = 0; k < len; k++) begin
            if (k == len / 2 && $urandom_range(0, 19) == 0) begin
              // retune mid-frame, only later headers change
              wait_drained();
              set_reg(2'($urandom_range(0, 3)), $urandom());
            end
            send_item(8'($urandom()), !by_empty && (k == len - 1), 1'b0, n_res, crc_out);
            sent++;
          end
          if (by_empty) begin
            send_item(8'($urandom()), 1'($urandom_range(0, 1)), 1'b1, n_res, crc_out);
            sent++;
          end
        end
      end
      wait_drained();
    end

    // drain and report
    in_valid_i <= 1'b0;
    while (bytes_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
